// ----- rtl/core/msm_pkg.sv -----
// Shared types, field widths, opcodes and saturation helpers for the mass-spring mesh step.
// No dependencies; every other file of the block but msm_ram imports this package.
package msm_pkg;

   localparam int VEC_W     = 32;
   localparam int INDEX_W   = 12;
   localparam int NB_W      = 10;
   localparam int REST_W    = 31;
   localparam int FIRST_W   = 12;
   localparam int DELTA_W   = 16;
   localparam int COUNT_W   = 11;
   localparam int SLOT_W    = FIRST_W + 1;     // first slot plus up to MAX_NEIGHBORS steps
   localparam int VEC3_W    = 3 * VEC_W;
   localparam int META_W    = 1 + FIRST_W;     // {pinned, first_spring}
   localparam int SPR_W     = 1 + REST_W + NB_W; // {end, rest, neighbor}
   localparam int WIDE_W    = 72;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W    = 1;
   localparam int QCNT_W    = 2;

   localparam logic [1:0] ACT_LOAD_VTX = 2'd0;
   localparam logic [1:0] ACT_LOAD_SPR = 2'd1;
   localparam logic [1:0] ACT_TICK     = 2'd2;
   localparam logic [1:0] ACT_READ     = 2'd3;

   typedef enum logic [2:0] {
      OP_NOP,
      OP_LOAD_VTX,
      OP_LOAD_SPR,
      OP_TICK,
      OP_READ
   } op_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_READ,
      S_P1_META,
      S_P1_LOAD,
      S_P1_VEL_MUL,
      S_P1_VEL_ADD,
      S_P1_PRED_MUL,
      S_P1_PRED_ADD,
      S_P1_SPR_RD,
      S_P1_SPR_CHK,
      S_P1_DIFF,
      S_P1_SQ_MUL,
      S_P1_SQ_ADD,
      S_P1_SQRT,
      S_P1_RATIO,
      S_P1_DIV,
      S_P1_FAC,
      S_P1_TERM_MUL,
      S_P1_TERM_ADD,
      S_P1_WB,
      S_P2_RD,
      S_P2_LOAD,
      S_P2_MUL,
      S_P2_ADD,
      S_P2_WB
   } state_type;

   typedef struct packed {
      logic [1:0]                action;
      logic [INDEX_W-1:0]        index;
      logic signed [VEC_W-1:0]   vec_x;
      logic signed [VEC_W-1:0]   vec_y;
      logic signed [VEC_W-1:0]   vec_z;
      logic [NB_W-1:0]           neighbor;
      logic [REST_W-1:0]         rest_length;
      logic [FIRST_W-1:0]        first_spring;
      logic                      pinned;
      logic                      end_of_list;
      logic [DELTA_W-1:0]        delta;
   } req_type;

   typedef struct packed {
      logic signed [VEC_W-1:0]   out_pos_x;
      logic signed [VEC_W-1:0]   out_pos_y;
      logic signed [VEC_W-1:0]   out_pos_z;
      logic signed [VEC_W-1:0]   out_vel_x;
      logic signed [VEC_W-1:0]   out_vel_y;
      logic signed [VEC_W-1:0]   out_vel_z;
      logic                      done_res;
      logic                      degenerate;
      logic                      saturated;
   } rsp_type;

   typedef struct packed {
      op_type  op;
      req_type req;
   } cmd_type;

   function automatic logic signed [VEC_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
      logic signed [VEC_W-1:0] r;
      if (v > 72'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (v < -72'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[VEC_W-1:0];
      end
      return r;
   endfunction

   function automatic logic ovf32(input logic signed [WIDE_W-1:0] v);
      return (v > 72'sd2147483647) || (v < -72'sd2147483648);
   endfunction

endpackage

// ----- rtl/core/msm_req_if.sv -----
// Request channel: valid/ready handshake carrying one request.
// Depends on msm_pkg for the payload type.
interface msm_req_if;
   import msm_pkg::*;
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/core/msm_rsp_if.sv -----
// Response channel: valid/ready handshake carrying one response.
// Depends on msm_pkg for the payload type.
interface msm_rsp_if;
   import msm_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/core/msm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module msm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule

// ----- rtl/core/msm_front.sv -----
// Front end: takes requests, checks index range and tags each with an opcode.
// Depends on msm_pkg and msm_req_if; feeds msm_queue.
module msm_front #(
   parameter int MAX_VERTICES = 1024,
   parameter int MAX_SPRINGS  = 4096
) (
   msm_req_if.sink            req,
   input  logic               full,
   output logic               push,
   output msm_pkg::cmd_type   cmd
);
   import msm_pkg::*;

   logic vtx_ok;
   logic spr_ok;

   assign vtx_ok   = 32'(req.payload.index) < 32'(MAX_VERTICES);
   assign spr_ok   = 32'(req.payload.index) < 32'(MAX_SPRINGS);
   assign req.ready = !full;
   assign push     = req.valid && !full;

   always_comb begin
      cmd.req = req.payload;
      case (req.payload.action)
         ACT_LOAD_VTX: cmd.op = vtx_ok ? OP_LOAD_VTX : OP_NOP;
         ACT_LOAD_SPR: cmd.op = spr_ok ? OP_LOAD_SPR : OP_NOP;
         ACT_TICK:     cmd.op = OP_TICK;
         ACT_READ:     cmd.op = vtx_ok ? OP_READ : OP_NOP;
         default:      cmd.op = OP_NOP;
      endcase
   end
endmodule

// ----- rtl/core/msm_queue.sv -----
// Two-entry command queue between the front end and the execution engine.
// Depends on msm_pkg.
module msm_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  msm_pkg::cmd_type push_data,
   input  logic             pop,
   output msm_pkg::cmd_type head,
   output logic             full,
   output logic             empty
);
   import msm_pkg::*;

   cmd_type             mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wptr_ff, wptr_in;
   logic [QPTR_W-1:0]   rptr_ff, rptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   assign full  = count_ff == QCNT_W'(QUEUE_DEPTH);
   assign empty = count_ff == '0;
   assign head  = mem_ff[rptr_ff];

   always_comb begin
      wptr_in  = wptr_ff + QPTR_W'(push);
      rptr_in  = rptr_ff + QPTR_W'(pop);
      count_in = count_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
      if (push) begin
         mem_ff[wptr_ff] <= push_data;
      end
   end
endmodule

// ----- rtl/core/msm_back.sv -----
// Execution engine: vertex/spring stores, shared multiplier, iterative sqrt and divider,
// tick sequencer and response register. Depends on msm_pkg, msm_rsp_if and msm_ram.
module msm_back #(
   parameter int MAX_VERTICES  = 1024,
   parameter int MAX_SPRINGS   = 4096,
   parameter int MAX_NEIGHBORS = 16,
   parameter int FRAC_BITS     = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         cmd_valid,
   input  msm_pkg::cmd_type             cmd,
   output logic                         cmd_pop,
   input  logic [msm_pkg::COUNT_W-1:0]  vertex_count,
   msm_rsp_if.source                    rsp
);
   import msm_pkg::*;

   localparam int VAW = $clog2(MAX_VERTICES);
   localparam int VCW = $clog2(MAX_VERTICES + 1);
   localparam int SAW = $clog2(MAX_SPRINGS);
   localparam int JW  = $clog2(MAX_NEIGHBORS + 1);
   localparam int GW  = VEC_W + JW + 1;
   localparam int DW  = 33 + FRAC_BITS;
   localparam int DCW = $clog2(DW + 1);

   // store ports
   logic              pos_we, vel_we, meta_we, spr_we;
   logic [VAW-1:0]    pos_waddr, vel_waddr, meta_waddr;
   logic [SAW-1:0]    spr_waddr;
   logic [VEC3_W-1:0] pos_wdata, vel_wdata, pos_rdata, vel_rdata;
   logic [META_W-1:0] meta_wdata, meta_rdata;
   logic [SPR_W-1:0]  spr_wdata, spr_rdata;
   logic [VAW-1:0]    pos_raddr, vel_raddr, meta_raddr;
   logic [SAW-1:0]    spr_raddr;

   // sequencer state
   state_type                state_ff, state_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_ff, rsp_in;
   logic signed [VEC_W-1:0]  acc_ff [3], acc_in [3];
   logic signed [VEC_W-1:0]  pos_ff [3], pos_in [3];
   logic signed [VEC_W-1:0]  vel_ff [3], vel_in [3];
   logic signed [VEC_W-1:0]  diff_ff [3], diff_in [3];
   logic signed [GW-1:0]     g_ff [3], g_in [3];
   logic [DELTA_W-1:0]       delta_ff, delta_in;
   logic [VCW-1:0]           n_ff, n_in;
   logic [VCW-1:0]           v_ff, v_in;
   logic [1:0]               comp_ff, comp_in;
   logic [SLOT_W-1:0]        slot_ff, slot_in;
   logic [JW-1:0]            j_ff, j_in;
   logic [REST_W-1:0]        rest_ff, rest_in;
   logic [63:0]              sum_ff, sum_in;
   logic [63:0]              root_ff, root_in;
   logic [63:0]              bit_ff, bit_in;
   logic [DW-1:0]            div_ff, div_in;
   logic [33:0]              rem_ff, rem_in;
   logic [DCW-1:0]           dcnt_ff, dcnt_in;
   logic                     neg_ff, neg_in;
   logic signed [VEC_W-1:0]  fac_ff, fac_in;
   logic                     degen_ff, degen_in;
   logic                     sat_ff, sat_in;

   // shared multiplier
   logic signed [VEC_W-1:0]  mul_a;
   logic signed [VEC_W:0]    mul_b;
   logic signed [64:0]       prod_ff;

   logic signed [65:0]       rnd_d, rnd_f;

   msm_ram #(.WIDTH(VEC3_W), .DEPTH(MAX_VERTICES)) u_pos (
      .clock(clock), .we(pos_we), .waddr(pos_waddr), .wdata(pos_wdata),
      .raddr(pos_raddr), .rdata(pos_rdata));
   msm_ram #(.WIDTH(VEC3_W), .DEPTH(MAX_VERTICES)) u_vel (
      .clock(clock), .we(vel_we), .waddr(vel_waddr), .wdata(vel_wdata),
      .raddr(vel_raddr), .rdata(vel_rdata));
   msm_ram #(.WIDTH(META_W), .DEPTH(MAX_VERTICES)) u_meta (
      .clock(clock), .we(meta_we), .waddr(meta_waddr), .wdata(meta_wdata),
      .raddr(meta_raddr), .rdata(meta_rdata));
   msm_ram #(.WIDTH(SPR_W), .DEPTH(MAX_SPRINGS)) u_spr (
      .clock(clock), .we(spr_we), .waddr(spr_waddr), .wdata(spr_wdata),
      .raddr(spr_raddr), .rdata(spr_rdata));

   assign rsp.valid   = rsp_valid_ff;
   assign rsp.payload = rsp_ff;

   // product rounded half up: by delta (Q0.16) and by the fraction width
   assign rnd_d = (66'(prod_ff) + 66'sd32768) >>> DELTA_W;
   assign rnd_f = (66'(prod_ff) + (66'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;

   always_comb begin
      logic signed [WIDE_W-1:0] t;
      logic [64:0]              trial;
      logic [33:0]              rem_sh;
      logic signed [33:0]       ext;
      logic [32:0]              ext_abs;
      logic signed [VEC_W-1:0]  term;
      int                       c;

      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      acc_in       = acc_ff;
      pos_in       = pos_ff;
      vel_in       = vel_ff;
      diff_in      = diff_ff;
      g_in         = g_ff;
      delta_in     = delta_ff;
      n_in         = n_ff;
      v_in         = v_ff;
      comp_in      = comp_ff;
      slot_in      = slot_ff;
      j_in         = j_ff;
      rest_in      = rest_ff;
      sum_in       = sum_ff;
      root_in      = root_ff;
      bit_in       = bit_ff;
      div_in       = div_ff;
      rem_in       = rem_ff;
      dcnt_in      = dcnt_ff;
      neg_in       = neg_ff;
      fac_in       = fac_ff;
      degen_in     = degen_ff;
      sat_in       = sat_ff;
      cmd_pop      = 1'b0;
      t            = '0;
      trial        = '0;
      rem_sh       = '0;
      ext          = '0;
      ext_abs      = '0;
      term         = '0;

      pos_we     = 1'b0;
      vel_we     = 1'b0;
      meta_we    = 1'b0;
      spr_we     = 1'b0;
      pos_waddr  = VAW'(v_ff);
      vel_waddr  = VAW'(v_ff);
      meta_waddr = VAW'(cmd.req.index);
      spr_waddr  = SAW'(cmd.req.index);
      pos_wdata  = {pos_ff[2], pos_ff[1], pos_ff[0]};
      vel_wdata  = '0;
      meta_wdata = {cmd.req.pinned, cmd.req.first_spring};
      spr_wdata  = {cmd.req.end_of_list, cmd.req.rest_length, cmd.req.neighbor};
      pos_raddr  = VAW'(v_ff);
      vel_raddr  = VAW'(v_ff);
      meta_raddr = VAW'(v_ff);
      spr_raddr  = SAW'(slot_ff);
      mul_a      = vel_ff[comp_ff];
      mul_b      = $signed({17'b0, delta_ff});

      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (cmd_valid && !rsp_valid_ff) begin
               cmd_pop = 1'b1;
               rsp_in  = '0;
               case (cmd.op)
                  OP_LOAD_VTX: begin
                     pos_we    = 1'b1;
                     pos_waddr = VAW'(cmd.req.index);
                     pos_wdata = {cmd.req.vec_z, cmd.req.vec_y, cmd.req.vec_x};
                     vel_we    = 1'b1;
                     vel_waddr = VAW'(cmd.req.index);
                     meta_we   = 1'b1;
                     rsp_in.done_res = 1'b1;
                     rsp_valid_in    = 1'b1;
                  end
                  OP_LOAD_SPR: begin
                     spr_we = 1'b1;
                     rsp_in.done_res = 1'b1;
                     rsp_valid_in    = 1'b1;
                  end
                  OP_READ: begin
                     pos_raddr = VAW'(cmd.req.index);
                     vel_raddr = VAW'(cmd.req.index);
                     state_in  = S_READ;
                  end
                  OP_TICK: begin
                     acc_in[0] = cmd.req.vec_x;
                     acc_in[1] = cmd.req.vec_y;
                     acc_in[2] = cmd.req.vec_z;
                     delta_in  = cmd.req.delta;
                     n_in      = (32'(vertex_count) > 32'(MAX_VERTICES)) ?
                                 VCW'(MAX_VERTICES) : VCW'(vertex_count);
                     v_in      = '0;
                     degen_in  = 1'b0;
                     sat_in    = 1'b0;
                     state_in  = S_P1_META;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;   // out-of-range index: not carried out
                  end
               endcase
            end
         end
         S_READ: begin
            rsp_in           = '0;
            rsp_in.out_pos_x = pos_rdata[31:0];
            rsp_in.out_pos_y = pos_rdata[63:32];
            rsp_in.out_pos_z = pos_rdata[95:64];
            rsp_in.out_vel_x = vel_rdata[31:0];
            rsp_in.out_vel_y = vel_rdata[63:32];
            rsp_in.out_vel_z = vel_rdata[95:64];
            rsp_in.done_res  = 1'b1;
            rsp_valid_in     = 1'b1;
            state_in         = S_IDLE;
         end
         S_P1_META: begin
            if (v_ff == n_ff) begin
               v_in     = '0;
               state_in = S_P2_RD;
            end else begin
               state_in = S_P1_LOAD;
            end
         end
         S_P1_LOAD: begin
            if (meta_rdata[FIRST_W]) begin
               v_in     = v_ff + 1'b1;
               state_in = S_P1_META;
            end else begin
               for (c = 0; c < 3; c++) begin
                  pos_in[c] = pos_rdata[c*VEC_W +: VEC_W];
                  vel_in[c] = vel_rdata[c*VEC_W +: VEC_W];
                  g_in[c]   = '0;
               end
               slot_in  = SLOT_W'(meta_rdata[FIRST_W-1:0]);
               j_in     = '0;
               comp_in  = '0;
               state_in = S_P1_VEL_MUL;
            end
         end
         S_P1_VEL_MUL: begin
            mul_a    = acc_ff[comp_ff];
            state_in = S_P1_VEL_ADD;
         end
         S_P1_VEL_ADD: begin
            t = WIDE_W'(vel_ff[comp_ff]) + WIDE_W'(rnd_d);
            vel_in[comp_ff] = sat32(t);
            sat_in = sat_ff | ovf32(t);
            if (comp_ff == 2'd2) begin
               comp_in  = '0;
               state_in = S_P1_PRED_MUL;
            end else begin
               comp_in  = comp_ff + 1'b1;
               state_in = S_P1_VEL_MUL;
            end
         end
         S_P1_PRED_MUL: begin
            state_in = S_P1_PRED_ADD;
         end
         S_P1_PRED_ADD: begin
            // own position is only needed for the prediction, so it is replaced
            t = WIDE_W'(pos_ff[comp_ff]) + WIDE_W'(rnd_d);
            pos_in[comp_ff] = sat32(t);
            sat_in = sat_ff | ovf32(t);
            if (comp_ff == 2'd2) begin
               comp_in  = '0;
               state_in = S_P1_SPR_RD;
            end else begin
               comp_in  = comp_ff + 1'b1;
               state_in = S_P1_PRED_MUL;
            end
         end
         S_P1_SPR_RD: begin
            if (32'(j_ff) == 32'(MAX_NEIGHBORS) || 32'(slot_ff) >= 32'(MAX_SPRINGS)) begin
               state_in = S_P1_WB;
            end else begin
               state_in = S_P1_SPR_CHK;
            end
         end
         S_P1_SPR_CHK: begin
            if (spr_rdata[SPR_W-1]) begin
               state_in = S_P1_WB;
            end else if (32'(spr_rdata[NB_W-1:0]) >= 32'(MAX_VERTICES)) begin
               j_in     = j_ff + 1'b1;
               slot_in  = slot_ff + 1'b1;
               state_in = S_P1_SPR_RD;
            end else begin
               pos_raddr = VAW'(spr_rdata[NB_W-1:0]);
               rest_in   = spr_rdata[NB_W +: REST_W];
               state_in  = S_P1_DIFF;
            end
         end
         S_P1_DIFF: begin
            for (c = 0; c < 3; c++) begin
               t = WIDE_W'($signed(pos_rdata[c*VEC_W +: VEC_W])) - WIDE_W'(pos_ff[c]);
               diff_in[c] = sat32(t);
               if (ovf32(t)) begin
                  sat_in = 1'b1;
               end
            end
            comp_in  = '0;
            sum_in   = '0;
            state_in = S_P1_SQ_MUL;
         end
         S_P1_SQ_MUL: begin
            mul_a    = diff_ff[comp_ff];
            mul_b    = 33'(diff_ff[comp_ff]);
            state_in = S_P1_SQ_ADD;
         end
         S_P1_SQ_ADD: begin
            sum_in = sum_ff + prod_ff[63:0];
            if (comp_ff == 2'd2) begin
               root_in  = '0;
               bit_in   = 64'h4000_0000_0000_0000;
               state_in = S_P1_SQRT;
            end else begin
               comp_in  = comp_ff + 1'b1;
               state_in = S_P1_SQ_MUL;
            end
         end
         S_P1_SQRT: begin
            // one result bit per cycle; sum_ff serves as the remainder
            trial = 65'(root_ff) + 65'(bit_ff);
            if ({1'b0, sum_ff} >= trial) begin
               sum_in  = sum_ff - trial[63:0];
               root_in = (root_ff >> 1) + bit_ff;
            end else begin
               root_in = root_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            if (bit_ff[0]) begin
               state_in = S_P1_RATIO;
            end
         end
         S_P1_RATIO: begin
            if (root_ff == '0) begin
               degen_in = 1'b1;
               j_in     = j_ff + 1'b1;
               slot_in  = slot_ff + 1'b1;
               state_in = S_P1_SPR_RD;
            end else begin
               ext     = $signed({2'b0, root_ff[31:0]}) - $signed({3'b0, rest_ff});
               ext_abs = ext[33] ? 33'(-ext) : ext[32:0];
               neg_in  = ext[33];
               div_in  = {ext_abs, {FRAC_BITS{1'b0}}};
               rem_in  = '0;
               dcnt_in = '0;
               state_in = S_P1_DIV;
            end
         end
         S_P1_DIV: begin
            // restoring division, one quotient bit per cycle
            rem_sh = {rem_ff[32:0], div_ff[DW-1]};
            if (rem_sh >= {2'b0, root_ff[31:0]}) begin
               rem_in = rem_sh - {2'b0, root_ff[31:0]};
               div_in = {div_ff[DW-2:0], 1'b1};
            end else begin
               rem_in = rem_sh;
               div_in = {div_ff[DW-2:0], 1'b0};
            end
            dcnt_in = dcnt_ff + 1'b1;
            if (32'(dcnt_ff) == 32'(DW - 1)) begin
               state_in = S_P1_FAC;
            end
         end
         S_P1_FAC: begin
            t = WIDE_W'($signed({1'b0, div_ff}));
            if (neg_ff) begin
               t = -t;
            end
            fac_in   = sat32(t);
            sat_in   = sat_ff | ovf32(t);
            comp_in  = '0;
            state_in = S_P1_TERM_MUL;
         end
         S_P1_TERM_MUL: begin
            mul_a    = diff_ff[comp_ff];
            mul_b    = 33'(fac_ff);
            state_in = S_P1_TERM_ADD;
         end
         S_P1_TERM_ADD: begin
            t    = WIDE_W'(rnd_f);
            term = sat32(t);
            sat_in = sat_ff | ovf32(t);
            g_in[comp_ff] = g_ff[comp_ff] + GW'(term);
            if (comp_ff == 2'd2) begin
               j_in     = j_ff + 1'b1;
               slot_in  = slot_ff + 1'b1;
               state_in = S_P1_SPR_RD;
            end else begin
               comp_in  = comp_ff + 1'b1;
               state_in = S_P1_TERM_MUL;
            end
         end
         S_P1_WB: begin
            for (c = 0; c < 3; c++) begin
               t = WIDE_W'(vel_ff[c]) + WIDE_W'(g_ff[c]);
               vel_wdata[c*VEC_W +: VEC_W] = sat32(t);
               if (ovf32(t)) begin
                  sat_in = 1'b1;
               end
            end
            vel_we   = 1'b1;
            v_in     = v_ff + 1'b1;
            state_in = S_P1_META;
         end
         S_P2_RD: begin
            if (v_ff == n_ff) begin
               rsp_in            = '0;
               rsp_in.done_res   = 1'b1;
               rsp_in.degenerate = degen_ff;
               rsp_in.saturated  = sat_ff;
               rsp_valid_in      = 1'b1;
               state_in          = S_IDLE;
            end else begin
               state_in = S_P2_LOAD;
            end
         end
         S_P2_LOAD: begin
            for (c = 0; c < 3; c++) begin
               pos_in[c] = pos_rdata[c*VEC_W +: VEC_W];
               vel_in[c] = vel_rdata[c*VEC_W +: VEC_W];
            end
            comp_in  = '0;
            state_in = S_P2_MUL;
         end
         S_P2_MUL: begin
            state_in = S_P2_ADD;
         end
         S_P2_ADD: begin
            t = WIDE_W'(pos_ff[comp_ff]) + WIDE_W'(rnd_d);
            pos_in[comp_ff] = sat32(t);
            sat_in = sat_ff | ovf32(t);
            if (comp_ff == 2'd2) begin
               state_in = S_P2_WB;
            end else begin
               comp_in  = comp_ff + 1'b1;
               state_in = S_P2_MUL;
            end
         end
         S_P2_WB: begin
            pos_we   = 1'b1;
            v_in     = v_ff + 1'b1;
            state_in = S_P2_RD;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff   <= rsp_in;
      acc_ff   <= acc_in;
      pos_ff   <= pos_in;
      vel_ff   <= vel_in;
      diff_ff  <= diff_in;
      g_ff     <= g_in;
      delta_ff <= delta_in;
      n_ff     <= n_in;
      v_ff     <= v_in;
      comp_ff  <= comp_in;
      slot_ff  <= slot_in;
      j_ff     <= j_in;
      rest_ff  <= rest_in;
      sum_ff   <= sum_in;
      root_ff  <= root_in;
      bit_ff   <= bit_in;
      div_ff   <= div_in;
      rem_ff   <= rem_in;
      dcnt_ff  <= dcnt_in;
      neg_ff   <= neg_in;
      fac_ff   <= fac_in;
      degen_ff <= degen_in;
      sat_ff   <= sat_in;
      prod_ff  <= 65'(mul_a) * 65'(mul_b);
   end
endmodule

// ----- rtl/core/mass_spring_mesh_step.sv -----
// Top level of the mass-spring mesh step: vertex_count register, front end, queue, engine.
// Depends on msm_pkg, msm_req_if, msm_rsp_if, msm_front, msm_queue and msm_back.
//
// Explicit Euler step over a spring-connected vertex set in Q16.16. Software loads vertices
// (position, pinned flag, first spring slot; velocity cleared) and spring slots (neighbor,
// rest length, end mark), writes vertex_count through the csr port, then issues a tick
// request carrying acceleration and delta. Each request gets exactly one response.
// Requests are classified by the front end and parked in a two-entry queue, so up to two new
// requests are taken while the engine works or a response waits in the output register.
// In the engine, a load or an out-of-range request is answered from S_IDLE, a read through
// S_READ (registered store read). A tick is carried out by one shared 32x33 multiplier, a
// one-bit-per-cycle square root and a one-bit-per-cycle divider, all sequenced per spring:
// pinned vertices are skipped in the velocity pass, each free vertex is updated with one
// square root per spring visited and one divide per spring of nonzero length, then a position
// pass covers every vertex. Stores are not cleared at reset: reading a vertex or slot never
// loaded returns whatever the RAM holds. No start-up clearing pass is needed.
module mass_spring_mesh_step #(
   parameter int MAX_VERTICES  = 1024,
   parameter int MAX_SPRINGS   = 4096,
   parameter int MAX_NEIGHBORS = 16,
   parameter int FRAC_BITS     = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   msm_req_if.sink                      req_chan,
   msm_rsp_if.source                    rsp_chan,
   input  logic                         csr_wr_en,
   input  logic [msm_pkg::COUNT_W-1:0]  csr_wr_data
);
   import msm_pkg::*;

   // vertex count register; the user must write it only while idle, the block does not enforce this
   logic [COUNT_W-1:0] vertex_count_ff, vertex_count_in;

   // front end to queue
   logic    push;
   cmd_type push_cmd;
   logic    q_full;

   // queue to engine
   cmd_type head_cmd;
   logic    q_empty;
   logic    pop;

   assign vertex_count_in = csr_wr_en ? csr_wr_data : vertex_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_count_ff <= '0;
      end else begin
         vertex_count_ff <= vertex_count_in;
      end
   end

   msm_front #(
      .MAX_VERTICES(MAX_VERTICES),
      .MAX_SPRINGS (MAX_SPRINGS)
   ) u_front (
      .req (req_chan),
      .full(q_full),
      .push(push),
      .cmd (push_cmd)
   );

   msm_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_data(push_cmd),
      .pop      (pop),
      .head     (head_cmd),
      .full     (q_full),
      .empty    (q_empty)
   );

   msm_back #(
      .MAX_VERTICES (MAX_VERTICES),
      .MAX_SPRINGS  (MAX_SPRINGS),
      .MAX_NEIGHBORS(MAX_NEIGHBORS),
      .FRAC_BITS    (FRAC_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_valid   (!q_empty),
      .cmd         (head_cmd),
      .cmd_pop     (pop),
      .vertex_count(vertex_count_ff),
      .rsp         (rsp_chan)
   );
endmodule

// ----- tb/tb.sv -----
// Self-checking bench for mass_spring_mesh_step: directed table, then random bursts of
// loads, spring edits, ticks and reads checked against a Q16.16 mesh predictor.
// Depends on msm_pkg, msm_req_if, msm_rsp_if and the mass_spring_mesh_step RTL.
module tb;
   import msm_pkg::*;

   localparam int NVTX = 1024;
   localparam int NSLOT = 4096;
   localparam int NBR_CAP = 16;

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic [COUNT_W-1:0] csr_wr_data;

   msm_req_if rq();
   msm_rsp_if rs();

   mass_spring_mesh_step dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (rq),
      .rsp_chan    (rs),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------- mesh predictor
   int          mesh_px[NVTX], mesh_py[NVTX], mesh_pz[NVTX];
   int          mesh_vx[NVTX], mesh_vy[NVTX], mesh_vz[NVTX];
   bit          mesh_pin[NVTX];
   bit [11:0]   mesh_first[NVTX];
   bit          vtx_loaded[NVTX];
   bit [9:0]    spr_nb[NSLOT];
   bit [30:0]   spr_rest[NSLOT];
   bit          spr_end[NSLOT];
   bit          slot_loaded[NSLOT];
   bit [10:0]   tick_count;
   bit          clipped;

   rsp_type     owed_rsp[$];
   int          fails = 0;

   // clamp to 32-bit signed, noting any clip for the tick's saturated flag
   function automatic int clamp32(longint v);
      if (v > 64'sd2147483647) begin
         clipped = 1'b1;
         return 32'sh7fffffff;
      end
      if (v < -64'sd2147483648) begin
         clipped = 1'b1;
         return 32'sh80000000;
      end
      return int'(v);
   endfunction

   function automatic longint round_q16(longint v);
      return (v + 64'sd32768) >>> 16;
   endfunction

   function automatic longint times_dt(int a, bit [15:0] d);
      longint dd;
      dd = longint'({48'd0, d});
      return round_q16(longint'(a) * dd);
   endfunction

   function automatic longint unsigned floor_sqrt(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n = n - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // one explicit Euler tick over the first n vertices
   function automatic rsp_type mesh_tick(req_type r);
      rsp_type o;
      int n, vx, vy, vz, qx, qy, qz, slot, nb;
      longint gx, gy, gz, dx, dy, dz, span, ext, fac;
      longint unsigned sum;
      bit degen;
      o = '0;
      degen = 1'b0;
      clipped = 1'b0;
      n = (tick_count > NVTX) ? NVTX : int'(tick_count);
      for (int v = 0; v < n; v++) begin
         if (mesh_pin[v]) continue;
         vx = clamp32(longint'(mesh_vx[v]) + times_dt(r.vec_x, r.delta));
         vy = clamp32(longint'(mesh_vy[v]) + times_dt(r.vec_y, r.delta));
         vz = clamp32(longint'(mesh_vz[v]) + times_dt(r.vec_z, r.delta));
         qx = clamp32(longint'(mesh_px[v]) + times_dt(vx, r.delta));
         qy = clamp32(longint'(mesh_py[v]) + times_dt(vy, r.delta));
         qz = clamp32(longint'(mesh_pz[v]) + times_dt(vz, r.delta));
         gx = 0; gy = 0; gz = 0;
         for (int j = 0; j < NBR_CAP; j++) begin
            slot = int'(mesh_first[v]) + j;
            if (slot >= NSLOT || spr_end[slot]) break;
            nb = spr_nb[slot];
            dx = clamp32(longint'(mesh_px[nb]) - qx);
            dy = clamp32(longint'(mesh_py[nb]) - qy);
            dz = clamp32(longint'(mesh_pz[nb]) - qz);
            sum = longint'(dx * dx) + longint'(dy * dy) + longint'(dz * dz);
            span = longint'(floor_sqrt(sum));
            if (span == 0) begin
               degen = 1'b1;
               continue;
            end
            ext = span - longint'({33'd0, spr_rest[slot]});
            fac = clamp32((ext * 64'sd65536) / span);
            gx += clamp32(round_q16(dx * fac));
            gy += clamp32(round_q16(dy * fac));
            gz += clamp32(round_q16(dz * fac));
         end
         mesh_vx[v] = clamp32(longint'(vx) + gx);
         mesh_vy[v] = clamp32(longint'(vy) + gy);
         mesh_vz[v] = clamp32(longint'(vz) + gz);
      end
      for (int v = 0; v < n; v++) begin
         mesh_px[v] = clamp32(longint'(mesh_px[v]) + times_dt(mesh_vx[v], r.delta));
         mesh_py[v] = clamp32(longint'(mesh_py[v]) + times_dt(mesh_vy[v], r.delta));
         mesh_pz[v] = clamp32(longint'(mesh_pz[v]) + times_dt(mesh_vz[v], r.delta));
      end
      o.done_res = 1'b1;
      o.degenerate = degen;
      o.saturated = clipped;
      return o;
   endfunction

   function automatic rsp_type mesh_apply(req_type r);
      rsp_type o;
      o = '0;
      case (r.action)
         ACT_LOAD_VTX: begin
            if (r.index < NVTX) begin
               mesh_px[r.index] = r.vec_x;
               mesh_py[r.index] = r.vec_y;
               mesh_pz[r.index] = r.vec_z;
               mesh_vx[r.index] = 0;
               mesh_vy[r.index] = 0;
               mesh_vz[r.index] = 0;
               mesh_pin[r.index] = r.pinned;
               mesh_first[r.index] = r.first_spring;
               vtx_loaded[r.index] = 1'b1;
               o.done_res = 1'b1;
            end
         end
         ACT_LOAD_SPR: begin
            spr_nb[r.index] = r.neighbor;
            spr_rest[r.index] = r.rest_length;
            spr_end[r.index] = r.end_of_list;
            slot_loaded[r.index] = 1'b1;
            o.done_res = 1'b1;
         end
         ACT_READ: begin
            if (r.index < NVTX) begin
               o.out_pos_x = mesh_px[r.index];
               o.out_pos_y = mesh_py[r.index];
               o.out_pos_z = mesh_pz[r.index];
               o.out_vel_x = mesh_vx[r.index];
               o.out_vel_y = mesh_vy[r.index];
               o.out_vel_z = mesh_vz[r.index];
               o.done_res = 1'b1;
            end
         end
         default: o = mesh_tick(r);
      endcase
      return o;
   endfunction

   // a tick may only touch vertices and slots that were loaded
   function automatic bit tick_touches_loaded_only();
      int n, slot;
      n = (tick_count > NVTX) ? NVTX : int'(tick_count);
      for (int v = 0; v < n; v++) begin
         if (!vtx_loaded[v]) return 1'b0;
         if (mesh_pin[v]) continue;
         for (int j = 0; j < NBR_CAP; j++) begin
            slot = int'(mesh_first[v]) + j;
            if (slot >= NSLOT) break;
            if (!slot_loaded[slot]) return 1'b0;
            if (spr_end[slot]) break;
            if (!vtx_loaded[spr_nb[slot]]) return 1'b0;
         end
      end
      return 1'b1;
   endfunction

   // ---------------------------------------------------------------- request driver
   int burst_left = 0;
   bit smooth_send = 1'b0;   // phase with no sender gaps

   function automatic req_type mk_req(bit [1:0] a, bit [11:0] idx, int x, int y, int z,
                                      bit [9:0] nb, bit [30:0] rest, bit [11:0] first,
                                      bit pin, bit eol, bit [15:0] d);
      req_type r;
      r.action = a;        r.index = idx;
      r.vec_x = x;         r.vec_y = y;         r.vec_z = z;
      r.neighbor = nb;     r.rest_length = rest; r.first_spring = first;
      r.pinned = pin;      r.end_of_list = eol;  r.delta = d;
      return r;
   endfunction

   // called at a rising edge; returns at the edge that accepted the request
   task automatic send_request(req_type r, bit typed, rsp_type want);
      int gap;
      bit taken;
      rsp_type got;
      if (burst_left == 0) begin
         gap = smooth_send ? 0 : $urandom_range(0, 7);
         if (gap != 0) begin
            rq.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      rq.valid <= 1'b1;
      rq.payload <= r;
      do begin
         @(negedge clock);
         taken = rq.ready;
         @(posedge clock);
      end while (!taken);
      got = mesh_apply(r);
      owed_rsp.push_back(typed ? want : got);
   endtask

   task automatic drain();
      rq.valid <= 1'b0;
      while (owed_rsp.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_count(bit [10:0] val);
      csr_wr_en <= 1'b1;
      csr_wr_data <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      tick_count = val;
   endtask

   // ---------------------------------------------------------------- response checker
   bit [15:0] stall_mask;
   bit        stall_on;

   initial begin
      int cyc;
      cyc = 0;
      rs.ready = 1'b0;
      stall_on = 1'b0;
      stall_mask = 16'hffff;
      forever begin
         @(posedge clock);
         cyc++;
         if (cyc % 300 == 0) begin
            stall_on = $urandom_range(0, 2) != 0;
            stall_mask = $urandom;
         end
         rs.ready <= !stall_on || stall_mask[cyc % 16];
      end
   end

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         fails++;
         $display("%0t %s expected %h actual %h", $time, name, want, got);
      end
   endtask

   // valid, ready and payload are stable at the falling edge before the accepting edge
   always @(negedge clock) begin
      rsp_type got, want;
      if (!reset && rs.valid === 1'b1 && rs.ready === 1'b1) begin
         got = rs.payload;
         if (owed_rsp.size() == 0) begin
            fails++;
            $display("%0t unexpected response, actual %h", $time, got);
         end else begin
            want = owed_rsp.pop_front();
            check_field("out_pos_x", want.out_pos_x, got.out_pos_x);
            check_field("out_pos_y", want.out_pos_y, got.out_pos_y);
            check_field("out_pos_z", want.out_pos_z, got.out_pos_z);
            check_field("out_vel_x", want.out_vel_x, got.out_vel_x);
            check_field("out_vel_y", want.out_vel_y, got.out_vel_y);
            check_field("out_vel_z", want.out_vel_z, got.out_vel_z);
            check_field("done_res", want.done_res, got.done_res);
            check_field("degenerate", want.degenerate, got.degenerate);
            check_field("saturated", want.saturated, got.saturated);
         end
      end
   end

   // ---------------------------------------------------------------- random content
   function automatic int rand_q16();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 80) return $signed($urandom_range(0, 1 << 24)) - (1 << 23);
      if (pick < 95) return $urandom;
      return pick[0] ? 32'sh7fffffff : 32'sh80000000;
   endfunction

   function automatic bit [15:0] rand_dt();
      return ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 8192));
   endfunction

   function automatic bit [30:0] rand_rest();
      return ($urandom_range(0, 4) == 0) ? 31'($urandom) : 31'($urandom_range(0, 1 << 22));
   endfunction

   function automatic bit [11:0] rand_far_index();
      return 12'($urandom_range(NVTX, 4095));
   endfunction

   // work region: vertices 0..15, slots 0..63
   function automatic req_type rand_request();
      int pick;
      bit pin;
      bit [11:0] idx, first;
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
         idx = ($urandom_range(0, 19) == 0) ? rand_far_index() : 12'($urandom_range(0, 15));
         pin = $urandom_range(0, 3) == 0;
         first = pin ? 12'($urandom) : 12'($urandom_range(0, 48));
         return mk_req(ACT_LOAD_VTX, idx, rand_q16(), rand_q16(), rand_q16(), '0, '0,
                       first, pin, 1'b0, rand_dt());
      end
      if (pick < 60)
         return mk_req(ACT_LOAD_SPR, 12'($urandom_range(0, 63)), 0, 0, 0,
                       10'($urandom_range(0, 15)), rand_rest(), '0, 1'b0,
                       $urandom_range(0, 2) == 0, '0);
      if (pick < 72) begin
         if (tick_touches_loaded_only())
            return mk_req(ACT_TICK, 12'($urandom), rand_q16(), rand_q16(), rand_q16(),
                          '0, '0, '0, 1'b0, 1'b0, rand_dt());
      end
      idx = ($urandom_range(0, 9) == 0) ? rand_far_index() : 12'($urandom_range(0, 15));
      return mk_req(ACT_READ, idx, 0, 0, 0, '0, '0, '0, 1'b0, 1'b0, '0);
   endfunction

   // ---------------------------------------------------------------- directed table
   typedef struct {
      req_type r;
      bit      typed;
      rsp_type want;
   } table_row;

   table_row plan[$];

   function automatic rsp_type mk_rsp(int x, int y, int z, bit done);
      rsp_type o;
      o = '0;
      o.out_pos_x = x; o.out_pos_y = y; o.out_pos_z = z;
      o.done_res = done;
      return o;
   endfunction

   task automatic add_row(req_type r, bit typed, rsp_type want);
      table_row row;
      row.r = r;
      row.typed = typed;
      row.want = want;
      plan.push_back(row);
   endtask

   task automatic build_plan();
      rsp_type none, done;
      none = '0;
      done = mk_rsp(0, 0, 0, 1'b1);
      // out-of-range read and load are dropped
      add_row(mk_req(ACT_READ, 12'd1024, 0, 0, 0, '0, '0, '0, 0, 0, '0), 1, none);
      add_row(mk_req(ACT_LOAD_VTX, 12'hfff, -1, -1, -1, 10'h3ff, '1, '1, 1, 1, '1), 1, none);
      // vertex 0 list: spring to 1, self spring, end
      add_row(mk_req(ACT_LOAD_SPR, 12'd0, 0, 0, 0, 10'd1, 31'h10000, '0, 0, 0, '0), 1, done);
      add_row(mk_req(ACT_LOAD_SPR, 12'd1, 0, 0, 0, 10'd0, 31'd0, '0, 0, 0, '0), 1, done);
      add_row(mk_req(ACT_LOAD_SPR, 12'd2, 0, 0, 0, 10'd0, 31'd0, '0, 0, 1, '0), 1, done);
      add_row(mk_req(ACT_LOAD_SPR, 12'd3, 0, 0, 0, 10'd0, 31'd0, '0, 0, 1, '0), 1, done);
      // last slot without end mark: walk runs off the table
      add_row(mk_req(ACT_LOAD_SPR, 12'hfff, 0, 0, 0, 10'd2, 31'h7fffffff, '0, 0, 0, '0),
              1, done);
      add_row(mk_req(ACT_LOAD_VTX, 12'd0, 0, 0, 0, '0, '0, 12'd0, 0, 0, '0), 1, done);
      add_row(mk_req(ACT_LOAD_VTX, 12'd1, 32'h20000, 0, 0, '0, '0, 12'd3, 0, 0, '0), 1, done);
      add_row(mk_req(ACT_LOAD_VTX, 12'd2, 32'sh7fffffff, 32'sh80000000, 0, '0, '0,
                     12'hfff, 0, 0, '0), 1, done);
      add_row(mk_req(ACT_READ, 12'd1, 0, 0, 0, '0, '0, '0, 0, 0, '0), 1,
              mk_rsp(32'h20000, 0, 0, 1'b1));
      // zero step: self springs come out zero length
      add_row(mk_req(ACT_TICK, 12'd0, 0, 0, 0, '0, '0, '0, 0, 0, 16'd0), 0, none);
      add_row(mk_req(ACT_TICK, 12'd0, 32'h8000, 32'h10000, -32'h4000, '0, '0, '0, 0, 0,
                     16'h1000), 0, none);
      add_row(mk_req(ACT_READ, 12'd0, 0, 0, 0, '0, '0, '0, 0, 0, '0), 0, none);
      add_row(mk_req(ACT_READ, 12'd1, 0, 0, 0, '0, '0, '0, 0, 0, '0), 0, none);
      // extreme acceleration and full step: saturation everywhere
      add_row(mk_req(ACT_TICK, 12'd0, 32'sh7fffffff, 32'sh80000000, 1, '0, '0, '0, 0, 0,
                     16'hffff), 0, none);
      add_row(mk_req(ACT_READ, 12'd2, 0, 0, 0, '0, '0, '0, 0, 0, '0), 0, none);
      // pinned vertex keeps zero velocity
      add_row(mk_req(ACT_LOAD_VTX, 12'd1, -32'h30000, 32'h10000, 0, '0, '0, 12'd0, 1, 0,
                     '0), 1, done);
      add_row(mk_req(ACT_TICK, 12'd0, 32'h10000, 0, 0, '0, '0, '0, 0, 0, 16'h8000), 0, none);
      add_row(mk_req(ACT_READ, 12'd1, 0, 0, 0, '0, '0, '0, 0, 0, '0), 0, none);
      add_row(mk_req(ACT_READ, 12'd0, 0, 0, 0, '0, '0, '0, 0, 0, '0), 0, none);
   endtask

   // ---------------------------------------------------------------- main sequence
   initial begin
      req_type r;
      rsp_type none;
      bit [10:0] counts[6];
      none = '0;
      counts = '{11'd0, 11'd16, 11'd1, 11'd8, 11'd16, 11'd5};
      reset = 1'b1;
      rq.valid = 1'b0;
      rq.payload = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      tick_count = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table on a three-vertex mesh
      write_count(11'd3);
      build_plan();
      foreach (plan[i]) send_request(plan[i].r, plan[i].typed, plan[i].want);
      drain();

      // fill the work region: slots first, so every list is fully loaded
      smooth_send = 1'b1;
      for (int s = 0; s < 64; s++)
         send_request(mk_req(ACT_LOAD_SPR, 12'(s), 0, 0, 0, 10'($urandom_range(0, 15)),
                             rand_rest(), '0, 0, (s < 40) && ($urandom_range(0, 2) == 0),
                             '0), 0, none);
      for (int v = 0; v < 16; v++)
         send_request(mk_req(ACT_LOAD_VTX, 12'(v), rand_q16(), rand_q16(), rand_q16(), '0,
                             '0, 12'($urandom_range(0, 48)), $urandom_range(0, 3) == 0, 0,
                             '0), 0, none);

      for (int ph = 0; ph < 6; ph++) begin
         drain();
         write_count(ph == 3 ? 11'($urandom_range(2, 15)) : counts[ph]);
         smooth_send = (ph == 2);
         for (int k = 0; k < 50; k++) send_request(rand_request(), 0, none);

         // once, mid-run: the whole vertex store, count above and at the maximum
         if (ph == 2) begin
            drain();
            write_count(11'd2047);
            send_request(mk_req(ACT_LOAD_SPR, 12'd100, 0, 0, 0, 10'd1023, rand_rest(), '0,
                                0, 0, '0), 0, none);
            send_request(mk_req(ACT_LOAD_SPR, 12'd101, 0, 0, 0, 10'd512, '0, '0, 0, 1, '0),
                         0, none);
            for (int v = 16; v < NVTX; v++)
               send_request(mk_req(ACT_LOAD_VTX, 12'(v), rand_q16(), rand_q16(), rand_q16(),
                                   '0, '0, (v % 97 == 0) ? 12'd100 : 12'($urandom), 
                                   v % 97 != 0, 0, '0), 0, none);
            r = mk_req(ACT_TICK, '0, rand_q16(), rand_q16(), rand_q16(), '0, '0, '0, 0, 0,
                       rand_dt());
            if (tick_touches_loaded_only()) send_request(r, 0, none);
            send_request(mk_req(ACT_READ, 12'd1023, 0, 0, 0, '0, '0, '0, 0, 0, '0), 0, none);
            send_request(mk_req(ACT_READ, 12'd97, 0, 0, 0, '0, '0, '0, 0, 0, '0), 0, none);
            drain();
            write_count(11'd1024);
            if (tick_touches_loaded_only()) send_request(r, 0, none);
            send_request(mk_req(ACT_READ, 12'd1023, 0, 0, 0, '0, '0, '0, 0, 0, '0), 0, none);
            send_request(mk_req(ACT_READ, 12'd194, 0, 0, 0, '0, '0, '0, 0, 0, '0), 0, none);
         end
      end

      drain();
      repeat (40) @(posedge clock);
      if (fails == 0) begin
         $display("mass_spring_mesh_step: match");
      end else begin
         $display("mass_spring_mesh_step: mismatch");
      end
      $finish;
   end

   // hard stop well beyond the slowest legal run
   initial begin
      #300000000;
      $display("mass_spring_mesh_step: mismatch");
      $finish;
   end

endmodule
